// File: src/rgbds_pkg.sv
`timescale 1ns / 1ps
// rgbds_pkg: shared constants for the rgb box average downscaler
// no dependencies; used by src/rgb_box_average_downscaler.sv

package rgbds_pkg;

    // channel and register field widths
    localparam int PIX_W    = 8;
    localparam int PIX_MAX  = 255;
    localparam int CHANNELS = 3;
    localparam int SCALE_W  = 4;
    localparam int DIM_W    = 13;
    localparam int CFG_W    = 13;

    // line count limit of a frame
    localparam int MAX_LINES = 4096;

    // channel order inside a line store word and the channel arrays
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCALE_FACTOR = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [SCALE_W-1:0] RST_SCALE  = 4'd3;
    localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd480;

    // marks that travel with a completed block
    typedef struct packed {
        logic emit;
        logic row_last;
        logic frame_last;
    } t_blk_marks;

endpackage

// File: src/rgb_box_average_downscaler.sv
`timescale 1ns / 1ps
// rgb_box_average_downscaler: integer-factor box filter downscaler for rgb pixels
// depends on rgbds_pkg (constants, register indexes, block mark struct)

// Pixels arrive in raster order, one request per cycle at most, and every pixel
// is taken in the cycle it is offered while the output side is not stalled. A
// pixel that completes a factor-by-factor block yields one averaged pixel after
// the line store read, sum and write back, reciprocal multiply and remainder
// correction stages; an output stall freezes the whole pipeline and so stalls the
// input. Per-column sums of the current block row live in a single-port-read,
// single-port-write line store of MAX_WIDTH words; the first line of each block
// row ignores the stored value, so the store needs no clearing after reset or a
// register write. A write to the scale, width or height register restarts the
// frame, and any register write must be done while the block is idle. Columns
// and lines beyond the last whole block are taken and dropped.
module rgb_box_average_downscaler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [rgbds_pkg::CFG_W-1:0]     i_cfg_data,
    // pixel input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rgbds_pkg::PIX_W-1:0]     i_pix_blue,
    input  logic [rgbds_pkg::PIX_W-1:0]     i_pix_green,
    input  logic [rgbds_pkg::PIX_W-1:0]     i_pix_red,
    // averaged pixel output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rgbds_pkg::PIX_W-1:0]     o_avg_blue,
    output logic [rgbds_pkg::PIX_W-1:0]     o_avg_green,
    output logic [rgbds_pkg::PIX_W-1:0]     o_avg_red,
    output logic                            o_row_end,
    output logic                            o_frame_end
);

    localparam int CH   = rgbds_pkg::CHANNELS;
    localparam int PW   = rgbds_pkg::PIX_W;
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int SW   = $clog2(MAX_FACTOR);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CXW  = WW + 1;
    localparam int YW   = $clog2(rgbds_pkg::MAX_LINES);
    localparam int HW   = $clog2(rgbds_pkg::MAX_LINES + 1);
    localparam int CYW  = HW + 1;
    localparam int RW   = $clog2(MAX_FACTOR * rgbds_pkg::PIX_MAX + 1);
    localparam int CW   = $clog2(MAX_FACTOR * MAX_FACTOR * rgbds_pkg::PIX_MAX + 1);
    localparam int MW   = CH * CW;
    localparam int RCW  = CW + 1;
    localparam int ARW  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int PRW  = CW + RCW;
    localparam int BKW  = CW + ARW;

    // configuration registers
    logic [rgbds_pkg::SCALE_W-1:0] r_scale;
    logic [rgbds_pkg::DIM_W-1:0]   r_width;
    logic [rgbds_pkg::DIM_W-1:0]   r_height;
    logic                          w_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= rgbds_pkg::RST_SCALE;
            r_width  <= rgbds_pkg::RST_WIDTH;
            r_height <= rgbds_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (rgbds_pkg::t_cfg_idx'(i_cfg_idx))
                rgbds_pkg::CFG_SCALE_FACTOR: r_scale  <= i_cfg_data[rgbds_pkg::SCALE_W-1:0];
                rgbds_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[rgbds_pkg::DIM_W-1:0];
                rgbds_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data[rgbds_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_restart = i_cfg_we &&
        (rgbds_pkg::t_cfg_idx'(i_cfg_idx) != rgbds_pkg::CFG_UNUSED);

    // clamped factor, width and height
    logic [FW-1:0] w_f;
    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;

    assign w_f = (r_scale == '0) ? FW'(1) :
                 ((32'(r_scale) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(r_scale));
    assign w_w = (r_width == '0) ? WW'(1) :
                 ((32'(r_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_width));
    assign w_h = (r_height == '0) ? HW'(1) :
                 ((32'(r_height) > rgbds_pkg::MAX_LINES) ? HW'(rgbds_pkg::MAX_LINES)
                                                         : HW'(r_height));

    // reciprocal and block area tables, indexed by the factor
    logic [RCW-1:0] w_rcp_tab  [MAX_FACTOR + 1];
    logic [ARW-1:0] w_area_tab [MAX_FACTOR + 1];

    for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_tab
        localparam int    AREA = (g == 0) ? 1 : g * g;
        localparam longint RCP = (longint'(1) << CW) / AREA;
        assign w_rcp_tab[g]  = RCW'(RCP);
        assign w_area_tab[g] = ARW'(AREA);
    end

    // pipeline advance and input handshake
    logic r_o_valid;
    logic w_adv;
    logic w_accept;

    assign w_adv    = !r_o_valid || !i_stall;
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    // raster position state
    logic [AW-1:0] r_x, r_x0, r_bc;
    logic [YW-1:0] r_y, r_y0;
    logic [SW-1:0] r_sub_col, r_sub_row;
    logic [RW-1:0] r_run [CH];

    logic [AW-1:0] n_x, n_x0, n_bc;
    logic [YW-1:0] n_y, n_y0;
    logic [SW-1:0] n_sub_col, n_sub_row;

    // block geometry of the current pixel
    logic [CXW-1:0] w_x_fit, w_x_next;
    logic [CYW-1:0] w_y_fit, w_y_next;
    logic           w_in_blk, w_run_end, w_row_done;
    logic [PW-1:0]  w_pix [CH];
    logic [RW-1:0]  w_run_sum [CH];

    assign w_pix[rgbds_pkg::CH_BLUE]  = i_pix_blue;
    assign w_pix[rgbds_pkg::CH_GREEN] = i_pix_green;
    assign w_pix[rgbds_pkg::CH_RED]   = i_pix_red;

    assign w_x_fit    = CXW'(r_x0) + CXW'(w_f);
    assign w_x_next   = w_x_fit + CXW'(w_f);
    assign w_y_fit    = CYW'(r_y0) + CYW'(w_f);
    assign w_y_next   = w_y_fit + CYW'(w_f);
    assign w_in_blk   = (w_x_fit <= CXW'(w_w)) && (w_y_fit <= CYW'(w_h));
    assign w_run_end  = (FW'(r_sub_col) + FW'(1)) >= w_f;
    assign w_row_done = (FW'(r_sub_row) + FW'(1)) >= w_f;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_run_sum[c] = r_run[c] + RW'(w_pix[c]);
        end
    end

    // next raster position
    always_comb begin
        n_x       = r_x + AW'(1);
        n_x0      = r_x0;
        n_bc      = r_bc;
        n_y       = r_y;
        n_y0      = r_y0;
        n_sub_col = r_sub_col + SW'(1);
        n_sub_row = r_sub_row;
        if (w_run_end) begin
            n_sub_col = '0;
            n_bc      = r_bc + AW'(1);
            n_x0      = r_x + AW'(1);
        end
        if ((WW'(r_x) + WW'(1)) >= w_w) begin
            n_x       = '0;
            n_x0      = '0;
            n_bc      = '0;
            n_sub_col = '0;
            n_y       = r_y + YW'(1);
            n_sub_row = r_sub_row + SW'(1);
            if (w_row_done) begin
                n_sub_row = '0;
                n_y0      = r_y + YW'(1);
            end
            if ((HW'(r_y) + HW'(1)) >= w_h) begin
                n_y       = '0;
                n_y0      = '0;
                n_sub_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_x       <= '0;
            r_x0      <= '0;
            r_bc      <= '0;
            r_y       <= '0;
            r_y0      <= '0;
            r_sub_col <= '0;
            r_sub_row <= '0;
            for (int c = 0; c < CH; c++) r_run[c] <= '0;
        end else if (w_accept) begin
            r_x       <= n_x;
            r_x0      <= n_x0;
            r_bc      <= n_bc;
            r_y       <= n_y;
            r_y0      <= n_y0;
            r_sub_col <= n_sub_col;
            r_sub_row <= n_sub_row;
            // run sum restarts after a run end, at line end and outside a whole block
            for (int c = 0; c < CH; c++) begin
                if ((WW'(r_x) + WW'(1)) >= w_w || (w_in_blk && w_run_end) || !w_in_blk) begin
                    r_run[c] <= '0;
                end else begin
                    r_run[c] <= w_run_sum[c];
                end
            end
        end
    end

    // stage 1: run end issues the line store read
    logic                 r_s1_valid;
    logic                 r_s1_first;
    rgbds_pkg::t_blk_marks r_s1_marks;
    logic [AW-1:0]        r_s1_bc;
    logic [RW-1:0]        r_s1_run [CH];
    logic [MW-1:0]        r_rd_data;
    logic                 w_s1_load;

    assign w_s1_load = w_accept && w_in_blk && w_run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_first            <= (r_sub_row == '0);
            r_s1_bc               <= r_bc;
            r_s1_marks.emit       <= w_row_done;
            r_s1_marks.row_last   <= (w_x_next > CXW'(w_w));
            r_s1_marks.frame_last <= (w_x_next > CXW'(w_w)) && (w_y_next > CYW'(w_h));
            for (int c = 0; c < CH; c++) r_s1_run[c] <= w_run_sum[c];
        end
    end

    // stage 2: add column sum, write back or hand on a finished block
    logic [CW-1:0] w_tot [CH];
    logic [MW-1:0] w_wr_data;
    logic          w_wr_en;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_tot[c] = (r_s1_first ? CW'(0) : r_rd_data[c*CW +: CW]) + CW'(r_s1_run[c]);
            w_wr_data[c*CW +: CW] = w_tot[c];
        end
    end

    assign w_wr_en = w_adv && r_s1_valid && !r_s1_marks.emit;

    // column sum line store
    logic [MW-1:0] r_col_mem [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_col_mem[r_s1_bc] <= w_wr_data;
        end
        if (w_s1_load) begin
            r_rd_data <= r_col_mem[r_bc];
        end
    end

    logic                  r_s2_valid;
    rgbds_pkg::t_blk_marks r_s2_marks;
    logic [CW-1:0]         r_s2_sum [CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_marks.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_marks <= r_s1_marks;
            for (int c = 0; c < CH; c++) r_s2_sum[c] <= w_tot[c];
        end
    end

    // stage 3: quotient estimate by reciprocal of the block area
    logic [PRW-1:0] w_prod [CH];
    logic [RCW-1:0] w_rcp;

    assign w_rcp = w_rcp_tab[w_f];

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_prod[c] = PRW'(r_s2_sum[c]) * PRW'(w_rcp);
        end
    end

    logic                  r_s3_valid;
    rgbds_pkg::t_blk_marks r_s3_marks;
    logic [CW-1:0]         r_s3_sum [CH];
    logic [CW-1:0]         r_s3_q0  [CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_marks <= r_s2_marks;
            for (int c = 0; c < CH; c++) begin
                r_s3_sum[c] <= r_s2_sum[c];
                r_s3_q0[c]  <= w_prod[c][CW +: CW];
            end
        end
    end

    // stage 4: remainder check corrects the estimate by at most one
    logic [ARW-1:0] w_area;
    logic [BKW-1:0] w_back [CH];
    logic [CW-1:0]  w_rem  [CH];
    logic [CW-1:0]  w_q    [CH];

    assign w_area = w_area_tab[w_f];

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_back[c] = BKW'(r_s3_q0[c]) * BKW'(w_area);
            w_rem[c]  = r_s3_sum[c] - w_back[c][CW-1:0];
            w_q[c]    = (w_rem[c] >= CW'(w_area)) ? (r_s3_q0[c] + CW'(1)) : r_s3_q0[c];
        end
    end

    // output register
    logic [PW-1:0] r_avg [CH];
    logic          r_row_end;
    logic          r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_row_end   <= r_s3_marks.row_last;
            r_frame_end <= r_s3_marks.frame_last;
            for (int c = 0; c < CH; c++) r_avg[c] <= w_q[c][PW-1:0];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_avg_blue  = r_avg[rgbds_pkg::CH_BLUE];
    assign o_avg_green = r_avg[rgbds_pkg::CH_GREEN];
    assign o_avg_red   = r_avg[rgbds_pkg::CH_RED];
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

endmodule
